[src/smet_pkg.sv]
`default_nettype none

package smet_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
   localparam int COORD_BITS    = 16;
   localparam int KEY_BITS      = 2 * COORD_BITS;
   localparam int VALUE_BITS    = 32;

   // item opcodes
   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_RETRIEVE = 2'd2,
      OP_UNUSED   = 2'd3
   } opcode_type;

endpackage

`default_nettype wire

[src/sparse_matrix_entry_table_core.sv]
`default_nettype none

// Sparse matrix coordinate list: holds up to 64 (row, column, value) entries.
// Pulse start with an item while busy is low; the block then walks every slot
// once through a single key compare (one slot per cycle from the key memory),
// applies the insert, delete or retrieve, and shows exactly one result for a
// single cycle with rsp_valid high. The result cannot be held off: it must be
// taken in that cycle. The scan reads all 64 slot keys from the key memory and
// compares each one; then the ACT state applies the operation and the RESP
// state shows the result. Busy drops in the cycle after the result, so the
// block takes no new item before it is through with the last one.
// Row and column match on their low 16 bits; an insert of a new coordinate
// into a full table is dropped and reported with rsp_table_full.
module sparse_matrix_entry_table_core (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire  [1:0]                           req_opcode,
   input  wire  [15:0]                          req_row_index,
   input  wire  [15:0]                          req_col_index,
   input  wire  signed [31:0]                   req_entry_value,
   output logic                                 rsp_valid,
   output logic signed [31:0]                   rsp_read_value,
   output logic                                 rsp_found,
   output logic                                 rsp_table_full
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_ACT  = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // slot storage
   logic [smet_pkg::TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [smet_pkg::KEY_BITS-1:0]      key_mem [smet_pkg::TABLE_ENTRIES];
   logic [smet_pkg::VALUE_BITS-1:0]    value_mem [smet_pkg::TABLE_ENTRIES];
   logic [smet_pkg::KEY_BITS-1:0]      key_rd_ff;
   logic [smet_pkg::VALUE_BITS-1:0]    value_rd_ff;

   // captured item
   smet_pkg::opcode_type            op_ff, op_in;
   logic [smet_pkg::KEY_BITS-1:0]   key_ff, key_in;
   logic [smet_pkg::VALUE_BITS-1:0] val_ff, val_in;

   // scan control
   logic [smet_pkg::CNT_BITS-1:0] issue_ff, issue_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic [smet_pkg::IDX_BITS-1:0] cmp_idx_ff, cmp_idx_in;
   logic                          hit_ff, hit_in;
   logic [smet_pkg::IDX_BITS-1:0] hit_idx_ff, hit_idx_in;
   logic                          free_ff, free_in;
   logic [smet_pkg::IDX_BITS-1:0] free_idx_ff, free_idx_in;

   // result
   logic found_ff, found_in;
   logic full_ff, full_in;
   logic rd_sel_ff, rd_sel_in;

   logic accept;
   logic issue_live;
   logic key_we, value_we;
   logic [smet_pkg::IDX_BITS-1:0] wr_idx;

   assign accept     = start && (state_ff == ST_IDLE);
   assign issue_live = issue_ff < smet_pkg::CNT_BITS'(smet_pkg::TABLE_ENTRIES);

   // sequencer and scan bookkeeping
   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      issue_in    = issue_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      found_in    = found_ff;
      full_in     = full_ff;
      rd_sel_in   = rd_sel_ff;
      key_we      = 1'b0;
      value_we    = 1'b0;
      wr_idx      = hit_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = smet_pkg::opcode_type'(req_opcode);
               key_in   = {req_row_index[smet_pkg::COORD_BITS-1:0],
                           req_col_index[smet_pkg::COORD_BITS-1:0]};
               val_in   = req_entry_value;
               issue_in = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one key read per cycle, compare the one read last cycle
            if (issue_live) begin
               issue_in   = issue_ff + smet_pkg::CNT_BITS'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[smet_pkg::IDX_BITS-1:0];
            end
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff] && key_rd_ff == key_ff && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = cmp_idx_ff;
               end
               if (!valid_ff[cmp_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == smet_pkg::IDX_BITS'(smet_pkg::TABLE_ENTRIES - 1)) begin
                  state_in = ST_ACT;
               end
            end
         end
         ST_ACT: begin
            found_in  = 1'b0;
            full_in   = 1'b0;
            rd_sel_in = 1'b0;
            case (op_ff)
               smet_pkg::OP_INSERT: begin
                  if (hit_ff) begin
                     value_we = 1'b1;
                     found_in = 1'b1;
                  end else if (free_ff) begin
                     wr_idx           = free_idx_ff;
                     key_we           = 1'b1;
                     value_we         = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     full_in = 1'b1;
                  end
               end
               smet_pkg::OP_DELETE: begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     found_in             = 1'b1;
                  end
               end
               smet_pkg::OP_RETRIEVE: begin
                  found_in  = hit_ff;
                  rd_sel_in = hit_ff;
               end
               default: begin
               end
            endcase
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      issue_ff    <= issue_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
      rd_sel_ff   <= rd_sel_in;
   end

   // key memory: one write or one scan read per cycle
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_idx] <= key_ff;
      end
      key_rd_ff <= key_mem[issue_ff[smet_pkg::IDX_BITS-1:0]];
   end

   // value memory: written at the matched or free slot, read at the matched slot
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[wr_idx] <= val_ff;
      end
      value_rd_ff <= value_mem[hit_idx_ff];
   end

   // result ports
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_read_value = (rsp_valid && rd_sel_ff) ? value_rd_ff : '0;
   assign rsp_found      = rsp_valid && found_ff;
   assign rsp_table_full = rsp_valid && full_ff;

`ifndef ASSERT_OFF
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block stayed busy after its result");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_table_full |-> !rsp_found)
      else $error("dropped insert reported a present coordinate");

   a_value_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_read_value != '0) |-> (rsp_found && rsp_valid))
      else $error("nonzero read value without a hit");
`endif

endmodule

`default_nettype wire
